// ----- hdl/gmm_pkg.sv -----
package gmm_pkg;

  // fixed field widths
  localparam int SAMPLE_W = 16;
  localparam int IDX_W    = 6;
  localparam int KIND_W   = 2;

  // defaults for the top-level parameters
  localparam int DEF_ROWS  = 7;
  localparam int DEF_SLOTS = 6;

  // queue depth between front and back
  localparam int FIFO_DEPTH = 4;

  typedef enum logic [KIND_W-1:0] {
    KIND_DAY   = 2'd0,
    KIND_SLOT  = 2'd1,
    KIND_GRAND = 2'd2
  } gmm_kind_e;

  // one classified sample travelling from front to back
  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic [IDX_W-1:0]           slot;
    logic [IDX_W-1:0]           day;
    logic                       day_first;
    logic                       row_first;
    logic                       day_end;
    logic                       grid_end;
  } gmm_entry_t;

  // everything of a result word except the mean
  typedef struct packed {
    gmm_kind_e                  kind;
    logic [IDX_W-1:0]           index;
    logic signed [SAMPLE_W-1:0] maximum;
    logic signed [SAMPLE_W-1:0] minimum;
    logic                       last;
  } gmm_tag_t;

endpackage

// ----- hdl/gmm_front.sv -----
module gmm_front import gmm_pkg::*; #(
  parameter int ROWS  = DEF_ROWS,
  parameter int SLOTS = DEF_SLOTS
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic signed [SAMPLE_W-1:0] sample_i,
  output logic                       push_vld_o,
  input  logic                       push_rdy_i,
  output gmm_entry_t                 push_data_o
);

  localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int ROW_W  = (ROWS > 1) ? $clog2(ROWS) : 1;

  logic [SLOT_W-1:0] slot_q, slot_d;
  logic [ROW_W-1:0]  day_q, day_d;
  logic              accept, at_day_end, at_last_row;

  assign accept      = in_valid_i && push_rdy_i;
  assign at_day_end  = (slot_q == SLOT_W'(SLOTS - 1));
  assign at_last_row = (day_q == ROW_W'(ROWS - 1));

  assign in_ready_o = push_rdy_i;
  assign push_vld_o = in_valid_i;

  always_comb begin
    push_data_o.sample    = sample_i;
    push_data_o.slot      = IDX_W'(slot_q);
    push_data_o.day       = IDX_W'(day_q);
    push_data_o.day_first = (slot_q == '0);
    push_data_o.row_first = (day_q == '0);
    push_data_o.day_end   = at_day_end;
    push_data_o.grid_end  = at_day_end && at_last_row;
  end

  always_comb begin
    slot_d = slot_q;
    day_d  = day_q;
    if (accept) begin
      if (at_day_end) begin
        slot_d = '0;
        day_d  = at_last_row ? '0 : day_q + 1'b1;
      end else begin
        slot_d = slot_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q <= '0;
      day_q  <= '0;
    end else begin
      slot_q <= slot_d;
      day_q  <= day_d;
    end
  end

endmodule

// ----- hdl/gmm_fifo.sv -----
module gmm_fifo import gmm_pkg::*; #(
  parameter int DEPTH = FIFO_DEPTH
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_vld_i,
  output logic       push_rdy_o,
  input  gmm_entry_t push_data_i,
  output logic       pop_vld_o,
  input  logic       pop_rdy_i,
  output gmm_entry_t pop_data_o
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  gmm_entry_t       slots_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0] count_q;
  logic             push, pop;

  assign push_rdy_o = (count_q != CNT_W'(DEPTH));
  assign pop_vld_o  = (count_q != '0);
  assign pop_data_o = slots_q[rd_ptr_q];
  assign push       = push_vld_i && push_rdy_o;
  assign pop        = pop_vld_o && pop_rdy_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push && !pop) begin
        count_q <= count_q + 1'b1;
      end else if (pop && !push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      slots_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// ----- hdl/gmm_back.sv -----
module gmm_back import gmm_pkg::*; #(
  parameter int ROWS  = DEF_ROWS,
  parameter int SLOTS = DEF_SLOTS,
  localparam int TOT_W  = SAMPLE_W + $clog2(ROWS * SLOTS),
  localparam int DIVR_W = $clog2(ROWS * SLOTS + 1)
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    pop_vld_i,
  output logic                    pop_rdy_o,
  input  gmm_entry_t              pop_data_i,
  output logic                    job_vld_o,
  input  logic                    job_rdy_i,
  output gmm_tag_t                job_tag_o,
  output logic signed [TOT_W-1:0] job_total_o,
  output logic [DIVR_W-1:0]       job_divr_o
);

  localparam int SLOT_W     = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int DAY_TOT_W  = SAMPLE_W + $clog2(SLOTS);
  localparam int SLOT_TOT_W = SAMPLE_W + $clog2(ROWS);
  localparam int MEM_W      = 2 * SAMPLE_W + SLOT_TOT_W;

  localparam logic [1:0] ST_ACC      = 2'd0;
  localparam logic [1:0] ST_DUMP_RD  = 2'd1;
  localparam logic [1:0] ST_DUMP_JOB = 2'd2;
  localparam logic [1:0] ST_GRAND    = 2'd3;

  logic [1:0]        state_q, state_d;
  logic              s1_vld_q;
  gmm_entry_t        s1_q;
  logic [SLOT_W-1:0] dump_j_q, dump_j_d;

  // per-slot running extremes and sums
  logic [MEM_W-1:0]  mem [SLOTS];
  logic [MEM_W-1:0]  rd_q, cur_w, wr_w, fwd_data_q;
  logic [SLOT_W-1:0] rd_addr, s1_addr, fwd_addr_q;
  logic              fwd_vld_q, rd_en;

  logic signed [SAMPLE_W-1:0]   day_hi_q, day_lo_q, grand_hi_q, grand_lo_q;
  logic signed [DAY_TOT_W-1:0]  day_tot_q;
  logic signed [TOT_W-1:0]      grand_tot_q;

  logic signed [SAMPLE_W-1:0]   x, cur_hi, cur_lo;
  logic signed [SLOT_TOT_W-1:0] cur_tot, x_slot, slot_tot_n;
  logic signed [DAY_TOT_W-1:0]  x_day, day_tot_n;
  logic signed [TOT_W-1:0]      x_grand, grand_tot_n;
  logic signed [SAMPLE_W-1:0]   day_hi_n, day_lo_n, slot_hi_n, slot_lo_n;
  logic signed [SAMPLE_W-1:0]   grand_hi_n, grand_lo_n;
  logic                         s1_fire, pop, grid_first;

  assign x          = s1_q.sample;
  assign x_day      = DAY_TOT_W'(x);
  assign x_slot     = SLOT_TOT_W'(x);
  assign x_grand    = TOT_W'(x);
  assign s1_addr    = s1_q.slot[SLOT_W-1:0];
  assign grid_first = s1_q.day_first && s1_q.row_first;

  // previous cycle's write is not yet visible in the registered read
  assign cur_w   = (fwd_vld_q && fwd_addr_q == s1_addr) ? fwd_data_q : rd_q;
  assign cur_hi  = cur_w[MEM_W-1 -: SAMPLE_W];
  assign cur_lo  = cur_w[SLOT_TOT_W +: SAMPLE_W];
  assign cur_tot = cur_w[SLOT_TOT_W-1:0];

  assign s1_fire = (state_q == ST_ACC) && s1_vld_q && (!s1_q.day_end || job_rdy_i);
  assign pop_rdy_o = (state_q == ST_ACC) && (!s1_vld_q || s1_fire) &&
                     !(s1_vld_q && s1_q.grid_end);
  assign pop     = pop_vld_i && pop_rdy_o;
  assign rd_en   = pop || (state_q == ST_DUMP_RD);
  assign rd_addr = (state_q == ST_ACC) ? pop_data_i.slot[SLOT_W-1:0] : dump_j_q;

  always_comb begin
    if (s1_q.day_first) begin
      day_hi_n  = x;
      day_lo_n  = x;
      day_tot_n = x_day;
    end else begin
      day_hi_n  = (x > day_hi_q) ? x : day_hi_q;
      day_lo_n  = (x < day_lo_q) ? x : day_lo_q;
      day_tot_n = day_tot_q + x_day;
    end
    if (s1_q.row_first) begin
      slot_hi_n  = x;
      slot_lo_n  = x;
      slot_tot_n = x_slot;
    end else begin
      slot_hi_n  = (x > cur_hi) ? x : cur_hi;
      slot_lo_n  = (x < cur_lo) ? x : cur_lo;
      slot_tot_n = cur_tot + x_slot;
    end
    if (grid_first) begin
      grand_hi_n  = x;
      grand_lo_n  = x;
      grand_tot_n = x_grand;
    end else begin
      grand_hi_n  = (x > grand_hi_q) ? x : grand_hi_q;
      grand_lo_n  = (x < grand_lo_q) ? x : grand_lo_q;
      grand_tot_n = grand_tot_q + x_grand;
    end
    wr_w = {slot_hi_n, slot_lo_n, slot_tot_n};
  end

  // job mux and sequencer
  always_comb begin
    state_d           = state_q;
    dump_j_d          = dump_j_q;
    job_vld_o         = 1'b0;
    job_tag_o.kind    = KIND_DAY;
    job_tag_o.index   = s1_q.day;
    job_tag_o.maximum = day_hi_n;
    job_tag_o.minimum = day_lo_n;
    job_tag_o.last    = !s1_q.grid_end;
    job_total_o       = TOT_W'(day_tot_n);
    job_divr_o        = DIVR_W'(SLOTS);
    case (state_q)
      ST_ACC: begin
        job_vld_o = s1_vld_q && s1_q.day_end;
        if (s1_fire && s1_q.grid_end) begin
          state_d  = ST_DUMP_RD;
          dump_j_d = '0;
        end
      end
      ST_DUMP_RD: begin
        state_d = ST_DUMP_JOB;
      end
      ST_DUMP_JOB: begin
        job_vld_o         = 1'b1;
        job_tag_o.kind    = KIND_SLOT;
        job_tag_o.index   = IDX_W'(dump_j_q);
        job_tag_o.maximum = cur_hi;
        job_tag_o.minimum = cur_lo;
        job_tag_o.last    = 1'b0;
        job_total_o       = TOT_W'(cur_tot);
        job_divr_o        = DIVR_W'(ROWS);
        if (job_rdy_i) begin
          if (dump_j_q == SLOT_W'(SLOTS - 1)) begin
            state_d = ST_GRAND;
          end else begin
            dump_j_d = dump_j_q + 1'b1;
            state_d  = ST_DUMP_RD;
          end
        end
      end
      ST_GRAND: begin
        job_vld_o         = 1'b1;
        job_tag_o.kind    = KIND_GRAND;
        job_tag_o.index   = '0;
        job_tag_o.maximum = grand_hi_q;
        job_tag_o.minimum = grand_lo_q;
        job_tag_o.last    = 1'b1;
        job_total_o       = grand_tot_q;
        job_divr_o        = DIVR_W'(ROWS * SLOTS);
        if (job_rdy_i) begin
          state_d = ST_ACC;
        end
      end
      default: begin
        state_d = ST_ACC;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_ACC;
      s1_vld_q  <= 1'b0;
      fwd_vld_q <= 1'b0;
      dump_j_q  <= '0;
    end else begin
      state_q   <= state_d;
      dump_j_q  <= dump_j_d;
      fwd_vld_q <= s1_fire;
      if (pop) begin
        s1_vld_q <= 1'b1;
      end else if (s1_fire) begin
        s1_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      s1_q <= pop_data_i;
    end
    // a stalled word keeps its forwarded copy
    rd_q <= rd_en ? mem[rd_addr] : cur_w;
    if (s1_fire) begin
      mem[s1_addr] <= wr_w;
      fwd_addr_q   <= s1_addr;
      fwd_data_q   <= wr_w;
      day_hi_q     <= day_hi_n;
      day_lo_q     <= day_lo_n;
      day_tot_q    <= day_tot_n;
      grand_hi_q   <= grand_hi_n;
      grand_lo_q   <= grand_lo_n;
      grand_tot_q  <= grand_tot_n;
    end
  end

endmodule

// ----- hdl/gmm_div.sv -----
module gmm_div import gmm_pkg::*; #(
  parameter int ROWS  = DEF_ROWS,
  parameter int SLOTS = DEF_SLOTS,
  localparam int TOT_W  = SAMPLE_W + $clog2(ROWS * SLOTS),
  localparam int DIVR_W = $clog2(ROWS * SLOTS + 1)
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       job_vld_i,
  output logic                       job_rdy_o,
  input  gmm_tag_t                   job_tag_i,
  input  logic signed [TOT_W-1:0]    job_total_i,
  input  logic [DIVR_W-1:0]          job_divr_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [KIND_W-1:0]          kind_o,
  output logic [IDX_W-1:0]           index_o,
  output logic signed [SAMPLE_W-1:0] maximum_o,
  output logic signed [SAMPLE_W-1:0] minimum_o,
  output logic signed [SAMPLE_W-1:0] mean_o,
  output logic                       last_o
);

  // |total| / n = (|total| * ceil(2^sh / n)) >> sh with sh = TOT_W + clog2(n),
  // exact for every |total| below 2^TOT_W
  localparam int GRID_N  = ROWS * SLOTS;
  localparam int RCP_W   = TOT_W + 1;
  localparam int PROD_W  = TOT_W + RCP_W;
  localparam int SH_DAY  = TOT_W + $clog2(SLOTS);
  localparam int SH_SLOT = TOT_W + $clog2(ROWS);
  localparam int SH_GRID = TOT_W + $clog2(GRID_N);
  localparam logic [RCP_W-1:0] RCP_DAY  =
    RCP_W'(((64'd1 << SH_DAY) + 64'(SLOTS) - 64'd1) / 64'(SLOTS));
  localparam logic [RCP_W-1:0] RCP_SLOT =
    RCP_W'(((64'd1 << SH_SLOT) + 64'(ROWS) - 64'd1) / 64'(ROWS));
  localparam logic [RCP_W-1:0] RCP_GRID =
    RCP_W'(((64'd1 << SH_GRID) + 64'(GRID_N) - 64'd1) / 64'(GRID_N));

  localparam logic [1:0] D_IDLE = 2'd0;
  localparam logic [1:0] D_BUSY = 2'd1;
  localparam logic [1:0] D_DONE = 2'd2;

  localparam logic [1:0] SEL_DAY  = 2'd0;
  localparam logic [1:0] SEL_SLOT = 2'd1;
  localparam logic [1:0] SEL_GRID = 2'd2;

  logic [1:0]                 st_q, st_d, sel_q, sel_d;
  logic [TOT_W-1:0]           mag, mag_q;
  logic [RCP_W-1:0]           rcp;
  logic [PROD_W-1:0]          prod_q;
  logic [SAMPLE_W-1:0]        quo;
  logic                       neg_q;
  gmm_tag_t                   tag_q, out_tag_q;
  logic signed [SAMPLE_W-1:0] mean_q;
  logic                       out_vld_q, job_take, out_load;

  assign job_rdy_o = (st_q == D_IDLE);
  assign job_take  = job_vld_i && job_rdy_o;
  assign out_load  = (st_q == D_DONE) && (!out_vld_q || out_ready_i);
  assign mag       = job_total_i[TOT_W-1] ? TOT_W'(-job_total_i) : TOT_W'(job_total_i);

  // equal counts share the same constants, so first match is enough
  always_comb begin
    if (job_divr_i == DIVR_W'(SLOTS)) begin
      sel_d = SEL_DAY;
    end else if (job_divr_i == DIVR_W'(ROWS)) begin
      sel_d = SEL_SLOT;
    end else begin
      sel_d = SEL_GRID;
    end
  end

  always_comb begin
    case (sel_q)
      SEL_DAY: begin
        rcp = RCP_DAY;
        quo = prod_q[SH_DAY +: SAMPLE_W];
      end
      SEL_SLOT: begin
        rcp = RCP_SLOT;
        quo = prod_q[SH_SLOT +: SAMPLE_W];
      end
      default: begin
        rcp = RCP_GRID;
        quo = prod_q[SH_GRID +: SAMPLE_W];
      end
    endcase
  end

  always_comb begin
    st_d = st_q;
    case (st_q)
      D_IDLE: if (job_take) st_d = D_BUSY;
      D_BUSY: st_d = D_DONE;
      D_DONE: if (out_load) st_d = D_IDLE;
      default: st_d = D_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q      <= D_IDLE;
      out_vld_q <= 1'b0;
    end else begin
      st_q <= st_d;
      if (out_load) begin
        out_vld_q <= 1'b1;
      end else if (out_ready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (job_take) begin
      tag_q <= job_tag_i;
      neg_q <= job_total_i[TOT_W-1];
      mag_q <= mag;
      sel_q <= sel_d;
    end
    if (st_q == D_BUSY) begin
      prod_q <= PROD_W'(mag_q) * PROD_W'(rcp);
    end
    if (out_load) begin
      out_tag_q <= tag_q;
      mean_q    <= $signed(neg_q ? -quo : quo);
    end
  end

  assign out_valid_o = out_vld_q;
  assign kind_o      = out_tag_q.kind;
  assign index_o     = out_tag_q.index;
  assign maximum_o   = out_tag_q.maximum;
  assign minimum_o   = out_tag_q.minimum;
  assign mean_o      = mean_q;
  assign last_o      = out_tag_q.last;

endmodule

// ----- hdl/grid_min_max_mean_stats.sv -----
// Row and column statistics over a ROWS x SLOTS grid of signed 1/16-degree
// samples taken in row-major order (one day of SLOTS readings, then the next
// day). Each accepted word is one sample. The last sample of a day yields one
// day word (kind day, index = day number) with max, min and the mean truncated
// toward zero; last is set on it unless it also closes the grid. The last
// sample of the grid then adds SLOTS slot words (kind slot, index = slot
// number) and one grand word (kind grand, index 0, last set). Counters wrap
// and the next sample starts a new grid. Rate: the front takes one sample per
// cycle into a FIFO_DEPTH-entry queue while the queue is not full; the back
// updates the running extremes and sums at one sample per cycle through a
// read-modify-write of the per-slot memory, unless a day word waits for the
// mean unit or the grid end is in progress. Every result goes through a
// shared mean unit that multiplies the magnitude of the sum by a constant
// reciprocal of the count: it takes a result, multiplies, then loads the
// output register, and takes no new result until that load. A day word holds
// the back until the mean unit takes it. The grid end adds SLOTS + 1 results,
// during which the back holds off the queue; the per-slot memory read overlaps
// the mean unit. Output stalls hold the mean unit and with it the back.
module grid_min_max_mean_stats import gmm_pkg::*; #(
  parameter int ROWS  = DEF_ROWS,
  parameter int SLOTS = DEF_SLOTS
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic signed [SAMPLE_W-1:0] sample_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [KIND_W-1:0]          kind_o,
  output logic [IDX_W-1:0]           index_o,
  output logic signed [SAMPLE_W-1:0] maximum_o,
  output logic signed [SAMPLE_W-1:0] minimum_o,
  output logic signed [SAMPLE_W-1:0] mean_o,
  output logic                       last_o
);

  localparam int TOT_W  = SAMPLE_W + $clog2(ROWS * SLOTS);
  localparam int DIVR_W = $clog2(ROWS * SLOTS + 1);

  // front -> queue
  logic       push_vld, push_rdy;
  gmm_entry_t push_data;
  // queue -> back
  logic       pop_vld, pop_rdy;
  gmm_entry_t pop_data;
  // back -> mean unit: one word minus its mean
  logic                    job_vld, job_rdy;
  gmm_tag_t                job_tag;
  logic signed [TOT_W-1:0] job_total;
  logic [DIVR_W-1:0]       job_divr;

  // position counters and classification
  gmm_front #(.ROWS(ROWS), .SLOTS(SLOTS)) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .sample_i    (sample_i),
    .push_vld_o  (push_vld),
    .push_rdy_i  (push_rdy),
    .push_data_o (push_data)
  );

  gmm_fifo #(.DEPTH(FIFO_DEPTH)) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_vld_i  (push_vld),
    .push_rdy_o  (push_rdy),
    .push_data_i (push_data),
    .pop_vld_o   (pop_vld),
    .pop_rdy_i   (pop_rdy),
    .pop_data_o  (pop_data)
  );

  // accumulators, slot memory and the grid-end result walk
  gmm_back #(.ROWS(ROWS), .SLOTS(SLOTS)) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_vld_i   (pop_vld),
    .pop_rdy_o   (pop_rdy),
    .pop_data_i  (pop_data),
    .job_vld_o   (job_vld),
    .job_rdy_i   (job_rdy),
    .job_tag_o   (job_tag),
    .job_total_o (job_total),
    .job_divr_o  (job_divr)
  );

  // mean unit and output register
  gmm_div #(.ROWS(ROWS), .SLOTS(SLOTS)) u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_vld_i   (job_vld),
    .job_rdy_o   (job_rdy),
    .job_tag_i   (job_tag),
    .job_total_i (job_total),
    .job_divr_i  (job_divr),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .kind_o      (kind_o),
    .index_o     (index_o),
    .maximum_o   (maximum_o),
    .minimum_o   (minimum_o),
    .mean_o      (mean_o),
    .last_o      (last_o)
  );

  // a job offered to a busy mean unit must not change under it
  a_job_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    job_vld && !job_rdy |=> job_vld && $stable(job_tag) && $stable(job_total) &&
                            $stable(job_divr))
    else $error("job changed while mean unit busy");

  // the final day of a grid is followed by slot words, so it never closes
  a_last_day_open: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_o == KIND_DAY && index_o == IDX_W'(ROWS - 1) |-> !last_o)
    else $error("last day word marked last");

  // the grand word always closes the burst and carries index zero
  a_grand_close: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_o == KIND_GRAND |-> last_o && index_o == '0)
    else $error("grand word malformed");

  // slot words never carry last
  a_slot_open: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_o == KIND_SLOT |-> !last_o)
    else $error("slot word marked last");

endmodule

// ----- tb/sv/grid_min_max_mean_stats_tb.sv -----
`timescale 1ns / 100ps

module grid_min_max_mean_stats_tb;
  import gmm_pkg::*;

  localparam int ROWS         = DEF_ROWS;
  localparam int SLOTS        = DEF_SLOTS;
  localparam int GRID_SIZE    = ROWS * SLOTS;
  // 12 full grids, so every sample ends up inside a closed grid
  localparam int GRID_COUNT   = 12;
  localparam int DRAIN_CYCLES = 200;
  localparam int CYCLE_LIMIT  = 400000;

  // one result word as the block should present it
  typedef struct {
    gmm_kind_e                  kind;
    logic [IDX_W-1:0]           index;
    logic signed [SAMPLE_W-1:0] maximum;
    logic signed [SAMPLE_W-1:0] minimum;
    logic signed [SAMPLE_W-1:0] mean;
    logic                       last;
  } stats_word_t;

  // Running grid statistics plus the queue of stats words still owed.
  class grid_stats_board;
    int     slot_pos;
    int     day_pos;
    longint day_hi, day_lo, day_sum;
    longint col_hi[SLOTS], col_lo[SLOTS], col_sum[SLOTS];
    longint grand_hi, grand_lo, grand_sum;
    stats_word_t pending_words[$];
    int     failures;
    int     samples_seen;
    int     words_seen;
    int     words_by_kind[3];

    function void queue_word(gmm_kind_e kind, int idx, longint hi, longint lo,
                             longint avg, bit last);
      stats_word_t w;
      w.kind    = kind;
      w.index   = idx[IDX_W-1:0];
      w.maximum = hi[SAMPLE_W-1:0];
      w.minimum = lo[SAMPLE_W-1:0];
      w.mean    = avg[SAMPLE_W-1:0];
      w.last    = last;
      pending_words.push_back(w);
    endfunction

    // fold one accepted sample into the running stats, queue what it closes
    function void note_sample(logic signed [SAMPLE_W-1:0] x);
      longint v;
      v = x;
      samples_seen++;

      if (slot_pos == 0) begin
        day_hi  = v;
        day_lo  = v;
        day_sum = 0;
      end else begin
        if (v > day_hi) day_hi = v;
        if (v < day_lo) day_lo = v;
      end
      day_sum += v;

      if (day_pos == 0) begin
        col_hi[slot_pos]  = v;
        col_lo[slot_pos]  = v;
        col_sum[slot_pos] = 0;
      end else begin
        if (v > col_hi[slot_pos]) col_hi[slot_pos] = v;
        if (v < col_lo[slot_pos]) col_lo[slot_pos] = v;
      end
      col_sum[slot_pos] += v;

      if (day_pos == 0 && slot_pos == 0) begin
        grand_hi  = v;
        grand_lo  = v;
        grand_sum = 0;
      end else begin
        if (v > grand_hi) grand_hi = v;
        if (v < grand_lo) grand_lo = v;
      end
      grand_sum += v;

      if (slot_pos + 1 < SLOTS) begin
        slot_pos++;
        return;
      end

      // SV signed division truncates toward zero, as the block must
      queue_word(KIND_DAY, day_pos, day_hi, day_lo, day_sum / SLOTS,
                 day_pos + 1 < ROWS);
      slot_pos = 0;
      if (day_pos + 1 < ROWS) begin
        day_pos++;
      end else begin
        for (int j = 0; j < SLOTS; j++)
          queue_word(KIND_SLOT, j, col_hi[j], col_lo[j], col_sum[j] / ROWS, 1'b0);
        queue_word(KIND_GRAND, 0, grand_hi, grand_lo, grand_sum / GRID_SIZE, 1'b1);
        day_pos = 0;
      end
    endfunction

    function void compare(string field, longint want, longint got);
      if (want != got) begin
        $error("%s mismatch: expected %0d, got %0d", field, want, got);
        failures++;
      end
    endfunction

    function void check_word(logic [KIND_W-1:0] kind, logic [IDX_W-1:0] idx,
                             logic signed [SAMPLE_W-1:0] hi,
                             logic signed [SAMPLE_W-1:0] lo,
                             logic signed [SAMPLE_W-1:0] avg, logic last);
      stats_word_t w;
      words_seen++;
      if (pending_words.size() == 0) begin
        $error("unexpected stats word: kind %0d index %0d", kind, idx);
        failures++;
        return;
      end
      w = pending_words.pop_front();
      if (w.kind <= KIND_GRAND) words_by_kind[w.kind]++;
      if ($isunknown({kind, idx, hi, lo, avg, last})) begin
        $error("stats word carries X/Z: kind %b index %b", kind, idx);
        failures++;
      end
      compare("kind", w.kind, kind);
      compare("index", w.index, idx);
      compare("maximum", w.maximum, hi);
      compare("minimum", w.minimum, lo);
      compare("mean", w.mean, avg);
      compare("last", w.last, last);
    endfunction

    function void close_out();
      if (pending_words.size() != 0) begin
        $error("%0d stats words never arrived", pending_words.size());
        failures++;
      end
    endfunction
  endclass

  logic                       clk_i = 1'b0;
  logic                       rst_ni = 1'b0;
  logic                       in_valid = 1'b0;
  logic                       in_ready;
  logic signed [SAMPLE_W-1:0] sample = '0;
  logic                       out_valid;
  logic                       out_ready = 1'b0;
  logic [KIND_W-1:0]          kind;
  logic [IDX_W-1:0]           index;
  logic signed [SAMPLE_W-1:0] maximum;
  logic signed [SAMPLE_W-1:0] minimum;
  logic signed [SAMPLE_W-1:0] mean;
  logic                       last;

  grid_stats_board board = new;
  int                  cycle_count = 0;
  logic signed [SAMPLE_W-1:0] prev_sample = '0;

  // 10 ns clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  grid_min_max_mean_stats #(
    .ROWS (ROWS),
    .SLOTS(SLOTS)
  ) u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .sample_i   (sample),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .kind_o     (kind),
    .index_o    (index),
    .maximum_o  (maximum),
    .minimum_o  (minimum),
    .mean_o     (mean),
    .last_o     (last)
  );

  // Monitors: everything is sampled at the rising edge; stimulus moves on the
  // falling edge, so nothing here races the block's own updates.
  always @(posedge clk_i) begin
    if (rst_ni && in_valid && in_ready) board.note_sample(sample);
    if (rst_ni && out_valid && out_ready)
      board.check_word(kind, index, maximum, minimum, mean, last);
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d stats words outstanding",
               cycle_count, board.pending_words.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Receiver back-pressure: a new mode after each run of random length. Modes are
  // always ready, mostly ready, mostly stalled, and ready one cycle in four,
  // so stalls land on day words as well as the grid-end burst.
  int stall_mode = 0;
  int stall_left = 0;
  int stall_tick = 0;

  always @(negedge clk_i) begin
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_left = $urandom_range(20, 150);
    end else begin
      stall_left--;
    end
    stall_tick++;
    case (stall_mode)
      0:       out_ready <= 1'b1;
      1:       out_ready <= ($urandom_range(0, 9) < 7);
      2:       out_ready <= ($urandom_range(0, 9) < 2);
      default: out_ready <= (stall_tick % 4 == 0);
    endcase
  end

  // Present one sample word and hold it until the block takes it.
  task automatic send_sample(logic signed [SAMPLE_W-1:0] v);
    @(negedge clk_i);
    in_valid <= 1'b1;
    sample   <= v;
    prev_sample = v;
    do @(posedge clk_i); while (!in_ready);
  endtask

  // Drop valid for an idle stretch whose length is given by n.
  task automatic idle_input(int n);
    @(negedge clk_i);
    in_valid <= 1'b0;
    repeat (n - 1) @(negedge clk_i);
  endtask

  // Mix of extremes, repeats (tie handling), everyday temperatures
  // and full-range noise.
  function automatic logic signed [SAMPLE_W-1:0] pick_sample();
    case ($urandom_range(0, 9))
      0:       return 16'sh8000;
      1:       return 16'sh7FFF;
      2:       return prev_sample;
      3, 4, 5: return $signed(SAMPLE_W'($urandom_range(0, 1600))) - 16'sd800;
      default: return $signed(SAMPLE_W'($urandom));
    endcase
  endfunction

  // Random part: bursts of random length, random gaps (sometimes none).
  task automatic send_stream(int count);
    int sent;
    int burst;
    sent = 0;
    while (sent < count) begin
      burst = $urandom_range(1, 24);
      for (int i = 0; i < burst && sent < count; i++) begin
        send_sample(pick_sample());
        sent++;
      end
      if ($urandom_range(0, 3) != 0) idle_input($urandom_range(1, 8));
    end
  endtask

  // Directed opening: four days of grid 0.
  //   day 0: all max-positive (ties everywhere)
  //   day 1: all max-negative
  //   day 2: alternating extremes, small negative sum -> mean truncates to 0
  //   day 3: sum -7 -> mean -1, not floor -2
  logic signed [SAMPLE_W-1:0] opening_days[24] = '{
    16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF,
    16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000,
    16'sh7FFF, 16'sh8000, 16'sh7FFF, 16'sh8000, 16'sh0000, -16'sd1,
    -16'sd7,   16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000
  };

  initial begin
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    for (int i = 0; i < 24; i++) begin
      send_sample(opening_days[i]);
      if (i == 11) idle_input(3);
    end
    send_stream(GRID_COUNT * GRID_SIZE - 24);

    @(negedge clk_i);
    in_valid <= 1'b0;

    // drain: all owed words, then a quiet window for strays
    while (board.pending_words.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    board.close_out();

    $display("run: %0d samples over %0d grids, %0d stats words received",
             board.samples_seen, board.samples_seen / GRID_SIZE, board.words_seen);
    $display("checked: %0d day, %0d slot, %0d grand words; %0d errors",
             board.words_by_kind[KIND_DAY], board.words_by_kind[KIND_SLOT],
             board.words_by_kind[KIND_GRAND], board.failures);
    if (board.failures == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
